// ----- hw/rtl/jhax_pkg.sv -----
// ----------------------------------------------------------------------------
// jhax_pkg
// Shared types, codes and tables of the hex audio extractor.
// ----------------------------------------------------------------------------
package jhax_pkg;

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [2:0] ST_DATA  = 3'd0;
  localparam logic [2:0] ST_END   = 3'd1;
  localparam logic [2:0] ST_ODD   = 3'd2;
  localparam logic [2:0] ST_NOKEY = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  localparam logic [3:0]  KEY_LEN        = 4'd9;
  localparam logic [7:0]  QUOTE          = 8'h22;
  localparam logic [15:0] WINDOW_DEFAULT = 16'd1024;

  // "audio":"
  localparam logic [7:0] KEY_CHARS [0:8] = '{
    8'h22, 8'h61, 8'h75, 8'h64, 8'h69, 8'h6f, 8'h22, 8'h3a, 8'h22
  };
  localparam logic [3:0] KEY_FAIL [0:8] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd0, 4'd1
  };

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  match_position;
    logic [15:0] bytes_searched;
    logic [3:0]  held_nibble;
    logic        nibble_pending;
    logic        held_nibble_bad;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_SEARCH, match_position: 4'd0, bytes_searched: 16'd0,
    held_nibble: 4'd0, nibble_pending: 1'b0, held_nibble_bad: 1'b0
  };

  typedef struct packed {
    logic       valid;
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       bad_hex;
  } result_t;

  function automatic result_t make_result(logic [2:0] st, logic [7:0] b, logic bad);
    result_t r;
    r.valid    = 1'b1;
    r.status   = st;
    r.out_byte = b;
    r.bad_hex  = bad;
    return r;
  endfunction

  // {bad, nibble}; a non-hex character reads as nibble 0
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [4:0] r;
    r = {1'b1, 4'd0};
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // failure links fall back at most twice before position 0
  function automatic logic [3:0] key_advance(logic [3:0] q, logic [7:0] c);
    logic [3:0] p;
    p = (q >= KEY_LEN) ? 4'd0 : q;
    if (p != 4'd0 && KEY_CHARS[p] != c) p = KEY_FAIL[p - 4'd1];
    if (p != 4'd0 && KEY_CHARS[p] != c) p = KEY_FAIL[p - 4'd1];
    if (p != 4'd0 && KEY_CHARS[p] != c) p = KEY_FAIL[p - 4'd1];
    if (KEY_CHARS[p] == c) p = p + 4'd1;
    return p;
  endfunction

endpackage

// ----- hw/rtl/jhax_if.sv -----
// ----------------------------------------------------------------------------
// jhax_if
// Valid/ready channels of the hex audio extractor: byte stream and results.
// ----------------------------------------------------------------------------
interface jhax_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_response;

  modport source (output valid, output in_byte, output end_of_response, input ready);
  modport sink   (input valid, input in_byte, input end_of_response, output ready);
endinterface

interface jhax_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       bad_hex;

  modport source (output valid, output status, output out_byte, output bad_hex, input ready);
  modport sink   (input valid, input status, input out_byte, input bad_hex, output ready);
endinterface

// ----- hw/rtl/jhax_step.sv -----
// ----------------------------------------------------------------------------
// jhax_step
// Per-byte logic: prefix match, window check, hex pairing, status select.
// ----------------------------------------------------------------------------
module jhax_step (
  input  jhax_pkg::state_t  cur,
  input  logic [15:0]       window,
  input  logic [7:0]        c,
  input  logic              eor,
  output jhax_pkg::state_t  nxt,
  output jhax_pkg::result_t res
);

  logic [3:0]  q;
  logic [15:0] cnt;
  logic [4:0]  hx;

  always_comb begin
    nxt = cur;
    res = '0;
    q   = jhax_pkg::key_advance(cur.match_position, c);
    cnt = cur.bytes_searched + 16'd1;
    hx  = jhax_pkg::hex_nibble(c);
    case (cur.phase)
      jhax_pkg::PH_SEARCH: begin
        if (cur.bytes_searched >= window) begin
          res       = jhax_pkg::make_result(jhax_pkg::ST_NOKEY, 8'd0, 1'b0);
          nxt.phase = jhax_pkg::PH_DONE;
        end else begin
          nxt.bytes_searched = cnt;
          if (q == jhax_pkg::KEY_LEN) begin
            nxt.match_position = 4'd0;
            nxt.phase          = jhax_pkg::PH_DECODE;
            if (eor) res = jhax_pkg::make_result(jhax_pkg::ST_TRUNC, 8'd0, 1'b0);
          end else begin
            nxt.match_position = q;
            if (cnt >= window || eor) begin
              res       = jhax_pkg::make_result(jhax_pkg::ST_NOKEY, 8'd0, 1'b0);
              nxt.phase = jhax_pkg::PH_DONE;
            end
          end
        end
      end
      jhax_pkg::PH_DECODE: begin
        if (!cur.nibble_pending) begin
          if (c == jhax_pkg::QUOTE) begin
            res       = jhax_pkg::make_result(jhax_pkg::ST_END, 8'd0, 1'b0);
            nxt.phase = jhax_pkg::PH_DONE;
          end else begin
            nxt.held_nibble     = hx[3:0];
            nxt.held_nibble_bad = hx[4];
            nxt.nibble_pending  = 1'b1;
            if (eor) res = jhax_pkg::make_result(jhax_pkg::ST_TRUNC, 8'd0, 1'b0);
          end
        end else if (c == jhax_pkg::QUOTE) begin
          res       = jhax_pkg::make_result(jhax_pkg::ST_ODD, 8'd0, 1'b0);
          nxt.phase = jhax_pkg::PH_DONE;
        end else begin
          nxt.nibble_pending  = 1'b0;
          nxt.held_nibble     = 4'd0;
          nxt.held_nibble_bad = 1'b0;
          res = jhax_pkg::make_result(eor ? jhax_pkg::ST_TRUNC : jhax_pkg::ST_DATA,
                                      {cur.held_nibble, hx[3:0]},
                                      cur.held_nibble_bad | hx[4]);
        end
      end
      default: begin
      end
    endcase
    if (eor) nxt = jhax_pkg::STATE_RESET;
  end

endmodule

// ----- hw/rtl/json_hex_audio_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// json_hex_audio_extractor_unit
// Finds the "audio":" key in a response stream and decodes the hex after it.
// ----------------------------------------------------------------------------
// Usage:
//   stream  - one response byte per transfer; end_of_response marks the last
//             byte of a response, after which the next byte starts a new one.
//   result  - zero or one result per byte: data byte, done, done with odd
//             nibble, prefix not found or truncated.
//   cfg_we / cfg_wdata - search window in bytes; write only while idle.
// Path: a transferred byte waits in the byte register, and its result is then
//   registered in the result register, which drives result; a stall can hold it.
// Throughput: one byte per cycle; the byte register and the result register
//   are the only stages, and all per-byte work sits between them.
// Stall: while a result waits on result.ready, a full byte register holds its byte
//   and stream.ready is low; an empty byte register can still take one more byte.
// Reset: window returns to 1024, the scan restarts at the searching phase,
//   and both registers are emptied.
// ----------------------------------------------------------------------------
module json_hex_audio_extractor_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  jhax_byte_if.sink            stream,
  jhax_result_if.source        result
);

  logic [15:0]       window;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_eor;
  jhax_pkg::state_t  state;
  jhax_pkg::state_t  state_next;
  jhax_pkg::result_t step_res;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [7:0]        out_byte;
  logic              out_bad;
  logic              advance;

  jhax_step u_step (
    .cur    (state),
    .window (window),
    .c      (s1_byte),
    .eor    (s1_eor),
    .nxt    (state_next),
    .res    (step_res)
  );

  assign advance      = s1_valid && (!out_valid || result.ready);
  assign stream.ready = !s1_valid || advance;

  assign result.valid    = out_valid;
  assign result.status   = out_status;
  assign result.out_byte = out_byte;
  assign result.bad_hex  = out_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= jhax_pkg::WINDOW_DEFAULT;
    end else if (cfg_we) begin
      window <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_byte <= stream.in_byte;
      s1_eor  <= stream.end_of_response;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jhax_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_status <= step_res.status;
      out_byte   <= step_res.out_byte;
      out_bad    <= step_res.bad_hex;
    end
  end

  a_stall_holds_byte : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte) && $stable(s1_eor))
    else $error("byte register changed while stalled");

  a_match_bounded : assert property (@(posedge clk) disable iff (rst)
    state.match_position < jhax_pkg::KEY_LEN)
    else $error("match position out of range");

  a_search_no_nibble : assert property (@(posedge clk) disable iff (rst)
    state.phase == jhax_pkg::PH_SEARCH |-> !state.nibble_pending && state.held_nibble == 4'd0)
    else $error("nibble held while searching");

  a_result_from_advance : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a byte");

endmodule
